// File: src/shr_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// shr_pkg: shared types and constants of the stereo Hermite resampler
// Payload structs, fixed-point widths and register addresses.
// ----------------------------------------------------------------------------
package shr_pkg;

	localparam int SampleBits = 16;
	localparam int FracBits   = 16;
	localparam int MaxOutputs = 64;
	localparam int GuardBits  = 8;
	localparam int PhaseBits  = FracBits + 9;
	localparam int RateBits   = 18;
	localparam int AccBits    = 40;
	localparam int CntBits    = $clog2(MaxOutputs + 1);

	// Division by 100 as a multiply by ceil(2^32 / 100) and a 32-bit shift. This is
	// exact for every magnitude below 2^27, which covers a 16-bit sample times a
	// 10-bit gain.
	localparam int RecipShift = 32;
	localparam logic [25:0] RecipHundred = 26'd42949673;

	localparam logic [PhaseBits-1:0] OneQ    = PhaseBits'(1) << FracBits;
	localparam logic [PhaseBits-1:0] StepMin = OneQ >> 6;
	localparam logic [PhaseBits-1:0] StepMax = PhaseBits'(255) << FracBits;

	localparam logic [3:0] AddrVolume = 4'h0;
	localparam logic [3:0] AddrEnable = 4'h4;
	localparam logic [3:0] AddrInRate = 4'h8;
	localparam logic [3:0] AddrOutRate = 4'hC;

	localparam logic OpSample = 1'b0;
	localparam logic OpClear  = 1'b1;

	typedef struct packed {
		logic                         op;
		logic signed [SampleBits-1:0] left_in;
		logic signed [SampleBits-1:0] right_in;
	} in_item_t;

	typedef struct packed {
		logic signed [SampleBits-1:0] left_out;
		logic signed [SampleBits-1:0] right_out;
		logic                         last;
	} out_item_t;

	typedef struct packed {
		logic                         start;
		logic [FracBits:0]            mu;
	} lane_ctl_t;

	function automatic logic signed [SampleBits-1:0] sat_sample(
		input logic signed [AccBits-1:0] v);
		logic signed [AccBits-1:0] hi;
		logic signed [AccBits-1:0] lo;
		begin
			hi = AccBits'((64'sd1 <<< (SampleBits - 1)) - 1);
			lo = -hi - 1;
			if (v > hi) begin
				sat_sample = hi[SampleBits-1:0];
			end else if (v < lo) begin
				sat_sample = lo[SampleBits-1:0];
			end else begin
				sat_sample = v[SampleBits-1:0];
			end
		end
	endfunction

endpackage
`default_nettype wire

// File: src/shr_lane.sv
`default_nettype none
// ----------------------------------------------------------------------------
// shr_lane: Hermite evaluator of one channel
// Horner evaluation over three multiply steps, each a multiply and then an accumulate.
// ----------------------------------------------------------------------------
module shr_lane (
	input  wire logic                                  clk,
	input  wire logic                                  arst_n,
	input  wire shr_pkg::lane_ctl_t                    ctl,
	input  wire logic signed [shr_pkg::SampleBits-1:0] ha,
	input  wire logic signed [shr_pkg::SampleBits-1:0] hb,
	input  wire logic signed [shr_pkg::SampleBits-1:0] hc,
	input  wire logic signed [shr_pkg::SampleBits-1:0] hd,
	output logic                                       done,
	output logic signed [shr_pkg::SampleBits-1:0]      result
);

	localparam int AB = shr_pkg::AccBits;
	localparam int PB = AB + shr_pkg::FracBits + 2;

	logic signed [AB-1:0] acc_q, k1_q, b2_q, add_q;
	logic signed [PB-1:0] prod_q;
	logic [shr_pkg::FracBits:0] mu_q;
	logic [2:0] step_q;
	logic       mul_q;
	logic signed [AB-1:0] m0, m1, k2, k3;
	logic signed [AB-1:0] fl, nxt, half;

	function automatic logic signed [AB-1:0] k1_shift(input logic signed [AB-1:0] v);
		k1_shift = v <<< shr_pkg::GuardBits;
	endfunction

	always_comb begin
		m0 = AB'(hc) - AB'(ha);
		m1 = AB'(hd) - AB'(hb);
		k2 = 6 * (AB'(hc) - AB'(hb)) - 2 * m0 - m1;
		k3 = 4 * (AB'(hb) - AB'(hc)) + m0 + m1;
		fl = AB'(prod_q >>> shr_pkg::FracBits);
		nxt = fl + add_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			step_q <= '0;
			mul_q  <= 1'b0;
			done   <= 1'b0;
		end else begin
			done <= 1'b0;
			if (ctl.start) begin
				step_q <= 3'd1;
				mul_q  <= 1'b1;
			end else if (mul_q) begin
				mul_q <= 1'b0;
			end else if (step_q != 3'd0) begin
				if (step_q == 3'd3) begin
					step_q <= 3'd0;
					done   <= 1'b1;
				end else begin
					step_q <= step_q + 3'd1;
					mul_q  <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.start) begin
			mu_q  <= ctl.mu;
			acc_q <= k3 <<< shr_pkg::GuardBits;
			add_q <= k2 <<< shr_pkg::GuardBits;
			k1_q  <= k1_shift(m0);
			b2_q  <= (AB'(hb) <<< (shr_pkg::GuardBits + 1));
		end else if (mul_q) begin
			prod_q <= PB'(acc_q) * $signed({1'b0, mu_q});
		end else if (step_q != 3'd0) begin
			acc_q <= nxt;
			add_q <= (step_q == 3'd1) ? k1_q : b2_q;
		end
	end

	always_comb begin
		half = (acc_q < 0) ? -((-acc_q) >>> (shr_pkg::GuardBits + 1))
			: (acc_q >>> (shr_pkg::GuardBits + 1));
		result = shr_pkg::sat_sample(half);
	end

endmodule
`default_nettype wire

// File: src/shr_divider.sv
`default_nettype none
// ----------------------------------------------------------------------------
// shr_divider: rate step divider
// Restoring division, one quotient bit per cycle, with saturation.
// ----------------------------------------------------------------------------
module shr_divider (
	input  wire logic                                  clk,
	input  wire logic                                  arst_n,
	input  wire logic                                  start,
	input  wire logic [shr_pkg::RateBits-1:0]          num,
	input  wire logic [shr_pkg::RateBits-1:0]          den,
	output logic                                       busy,
	output logic [shr_pkg::PhaseBits-1:0]              step
);

	localparam int QB = shr_pkg::RateBits + shr_pkg::FracBits;
	localparam int CB = $clog2(QB + 1);

	logic [QB-1:0] dvd_q;
	logic [QB-1:0] quo_q;
	logic [shr_pkg::RateBits:0] rem_q;
	logic [shr_pkg::RateBits-1:0] den_q;
	logic [CB-1:0] cnt_q;
	logic [shr_pkg::RateBits:0] trial;

	assign trial = {rem_q[shr_pkg::RateBits-1:0], dvd_q[QB-1]};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy  <= 1'b0;
			cnt_q <= '0;
			step  <= shr_pkg::OneQ;
		end else if (start) begin
			busy  <= 1'b1;
			cnt_q <= CB'(QB);
		end else if (busy) begin
			if (cnt_q == CB'(0)) begin
				busy <= 1'b0;
				if (quo_q < QB'(shr_pkg::StepMin)) begin
					step <= shr_pkg::StepMin;
				end else if (quo_q > QB'(shr_pkg::StepMax)) begin
					step <= shr_pkg::StepMax;
				end else begin
					step <= shr_pkg::PhaseBits'(quo_q);
				end
			end else begin
				cnt_q <= cnt_q - CB'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			dvd_q <= {num, shr_pkg::FracBits'(0)};
			den_q <= den;
			rem_q <= '0;
			quo_q <= '0;
		end else if (busy && cnt_q != CB'(0)) begin
			dvd_q <= dvd_q << 1;
			if (trial >= {1'b0, den_q}) begin
				rem_q <= trial - {1'b0, den_q};
				quo_q <= {quo_q[QB-2:0], 1'b1};
			end else begin
				rem_q <= trial;
				quo_q <= {quo_q[QB-2:0], 1'b0};
			end
		end
	end

endmodule
`default_nettype wire

// File: src/stereo_hermite_resampler_core.sv
`default_nettype none
// ----------------------------------------------------------------------------
// stereo_hermite_resampler_core: four-tap Hermite stereo resampler
// Volume scaling, four-entry histories, two Hermite lanes and a merge stage.
// ----------------------------------------------------------------------------
// Items are taken one at a time. A bypassed item passes through SCALE, DIV, PUSH
// and EMIT. In resampling mode each output pair takes a lane launch, three
// multiply steps in the lanes and the output handshake; a pair past the cap is
// evaluated but not emitted, and recycles through PUSH. A rate write stalls input
// during the division. Reset is asynchronous, active low, restores defaults.
module stereo_hermite_resampler_core (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 in_valid,
	output logic                      in_ready,
	input  wire shr_pkg::in_item_t    in_data,
	output logic                      out_valid,
	input  wire logic                 out_ready,
	output shr_pkg::out_item_t        out_data,
	input  wire logic                 psel,
	input  wire logic                 penable,
	input  wire logic                 pwrite,
	input  wire logic [3:0]           paddr,
	input  wire logic [31:0]          pwdata,
	output logic [31:0]               prdata,
	output logic                      pready
);

	localparam int SB = shr_pkg::SampleBits;
	localparam int PH = shr_pkg::PhaseBits;

	// State machine of the sequencer, one-hot.
	typedef enum logic [5:0] {
		ST_IDLE  = 6'b000001,
		ST_SCALE = 6'b000010,
		ST_DIV   = 6'b000100,
		ST_PUSH  = 6'b001000,
		ST_EVAL  = 6'b010000,
		ST_EMIT  = 6'b100000
	} state_t;

	state_t state_q;

	logic [9:0]  volume_q;
	logic        enable_q;
	logic [shr_pkg::RateBits-1:0] in_rate_q, out_rate_q;
	logic [PH-1:0] phase_q;
	logic [PH-1:0] step;
	logic signed [SB-1:0] lh_q [4];
	logic signed [SB-1:0] rh_q [4];
	logic signed [SB+10:0] lprod_s1, rprod_s1;
	logic signed [SB-1:0]  lsc, rsc;
	logic [shr_pkg::CntBits-1:0] n_q;
	logic div_start, div_busy, wr;
	logic l_done, r_done;
	logic signed [SB-1:0] l_res, r_res;
	shr_pkg::lane_ctl_t ctl;
	logic more;

	assign pready = 1'b1;
	assign wr = psel && penable && pwrite;
	assign div_start = wr && (paddr == shr_pkg::AddrInRate || paddr == shr_pkg::AddrOutRate);

	always_comb begin
		unique case (paddr)
			shr_pkg::AddrVolume:  prdata = {22'd0, volume_q};
			shr_pkg::AddrEnable:  prdata = {31'd0, enable_q};
			shr_pkg::AddrInRate:  prdata = {14'd0, in_rate_q};
			shr_pkg::AddrOutRate: prdata = {14'd0, out_rate_q};
			default:              prdata = '0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			volume_q   <= 10'd100;
			enable_q   <= 1'b0;
			in_rate_q  <= 18'd1;
			out_rate_q <= 18'd1;
		end else if (wr) begin
			unique case (paddr)
				shr_pkg::AddrVolume: volume_q <= pwdata[9:0];
				shr_pkg::AddrEnable: enable_q <= pwdata[0];
				shr_pkg::AddrInRate:
					in_rate_q <= (pwdata[17:0] == 18'd0) ? 18'd1 : pwdata[17:0];
				shr_pkg::AddrOutRate:
					out_rate_q <= (pwdata[17:0] == 18'd0) ? 18'd1 : pwdata[17:0];
				default: ;
			endcase
		end
	end

	// The divider works on the register values after the write lands.
	logic div_go_q;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) div_go_q <= 1'b0;
		else div_go_q <= div_start;
	end

	shr_divider u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (div_go_q),
		.num    (in_rate_q),
		.den    (out_rate_q),
		.busy   (div_busy),
		.step   (step)
	);

	// Volume scale: truncate toward zero, then saturate. The division by 100 is a
	// reciprocal multiply on the magnitude.
	function automatic logic signed [SB-1:0] scale_div(input logic signed [SB+10:0] p);
		logic [SB+10:0] mag;
		logic [SB+36:0] prod;
		logic [SB+10:0] q;
		logic signed [shr_pkg::AccBits-1:0] v;
		begin
			mag = p[SB+10] ? (~p + 1'b1) : p;
			prod = (SB+37)'(mag) * (SB+37)'(shr_pkg::RecipHundred);
			q = (SB+11)'(prod[SB+36:shr_pkg::RecipShift]);
			v = p[SB+10] ? -shr_pkg::AccBits'(q) : shr_pkg::AccBits'(q);
			scale_div = shr_pkg::sat_sample(v);
		end
	endfunction

	assign lsc = scale_div(lprod_s1);
	assign rsc = scale_div(rprod_s1);

	assign in_ready = (state_q == ST_IDLE) && !div_busy && !div_go_q && !div_start;
	assign more = (phase_q <= shr_pkg::OneQ);

	always_comb begin
		ctl.start = (state_q == ST_PUSH && enable_q && more) ||
			(state_q == ST_EMIT && out_ready && enable_q && more);
		ctl.mu = phase_q[shr_pkg::FracBits:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_IDLE;
			phase_q   <= '0;
			out_valid <= 1'b0;
			n_q       <= '0;
			for (int i = 0; i < 4; i++) begin
				lh_q[i] <= '0;
				rh_q[i] <= '0;
			end
		end else begin
			if (div_go_q) phase_q <= '0;
			unique case (state_q)
				ST_IDLE: begin
					if (in_valid && in_ready) begin
						if (in_data.op == shr_pkg::OpClear) begin
							for (int i = 0; i < 4; i++) begin
								lh_q[i] <= '0;
								rh_q[i] <= '0;
							end
							phase_q <= '0;
						end else begin
							state_q <= ST_SCALE;
						end
					end
				end
				ST_SCALE: state_q <= ST_DIV;
				ST_DIV: begin
					for (int i = 0; i < 3; i++) begin
						lh_q[i] <= lh_q[i+1];
						rh_q[i] <= rh_q[i+1];
					end
					lh_q[3] <= lsc;
					rh_q[3] <= rsc;
					n_q     <= '0;
					state_q <= ST_PUSH;
				end
				ST_PUSH: begin
					if (!enable_q) begin
						out_data.left_out  <= lh_q[3];
						out_data.right_out <= rh_q[3];
						out_data.last      <= 1'b1;
						out_valid <= 1'b1;
						state_q   <= ST_EMIT;
					end else if (more) begin
						state_q <= ST_EVAL;
					end else begin
						phase_q <= phase_q - shr_pkg::OneQ;
						state_q <= ST_IDLE;
					end
				end
				ST_EVAL: begin
					if (l_done) begin
						if (n_q < shr_pkg::CntBits'(shr_pkg::MaxOutputs)) begin
							phase_q <= phase_q + step;
							n_q <= n_q + 1'b1;
							out_data.left_out  <= l_res;
							out_data.right_out <= r_res;
							out_data.last <= (phase_q + step > shr_pkg::OneQ) ||
								(n_q == shr_pkg::CntBits'(shr_pkg::MaxOutputs - 1));
							out_valid <= 1'b1;
							state_q   <= ST_EMIT;
						end else if (phase_q + step > shr_pkg::OneQ) begin
							phase_q <= phase_q + step - shr_pkg::OneQ;
							state_q <= ST_IDLE;
						end else begin
							phase_q <= phase_q + step;
							state_q <= ST_PUSH;
						end
					end
				end
				ST_EMIT: begin
					if (out_ready) begin
						out_valid <= 1'b0;
						if (!enable_q) begin
							state_q <= ST_IDLE;
						end else if (more) begin
							state_q <= ST_EVAL;
						end else begin
							phase_q <= phase_q - shr_pkg::OneQ;
							state_q <= ST_IDLE;
						end
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_IDLE) begin
			lprod_s1 <= (SB+11)'(in_data.left_in) * $signed({1'b0, volume_q});
			rprod_s1 <= (SB+11)'(in_data.right_in) * $signed({1'b0, volume_q});
		end
	end

	// After the cap, pairs are dropped and recycle through PUSH, which relaunches both lanes.
	shr_lane u_left (
		.clk (clk), .arst_n (arst_n), .ctl (ctl),
		.ha (lh_q[0]), .hb (lh_q[1]), .hc (lh_q[2]), .hd (lh_q[3]),
		.done (l_done), .result (l_res)
	);

	shr_lane u_right (
		.clk (clk), .arst_n (arst_n), .ctl (ctl),
		.ha (rh_q[0]), .hb (rh_q[1]), .hc (rh_q[2]), .hd (rh_q[3]),
		.done (r_done), .result (r_res)
	);

	// Both lanes run in lock step.
	a_lanes_sync: assert property (@(posedge clk) disable iff (!arst_n) l_done == r_done)
		else $error("lanes out of step");
	a_no_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		div_busy |-> !in_ready) else $error("item accepted during divide");
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid) else $error("result dropped");

endmodule
`default_nettype wire
